>>> hdl/log_frame_builder_macros.svh
// ----------------------------------------------------------------------------
// log_frame_builder_macros: assertion helpers for the log frame builder
// Each macro checks on the rising edge of clk and is off during reset.
// ----------------------------------------------------------------------------
`ifndef LOG_FRAME_BUILDER_MACROS_SVH
`define LOG_FRAME_BUILDER_MACROS_SVH

// same-cycle implication
`define LFB_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LFB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/lfb_pkg.sv
// ----------------------------------------------------------------------------
// lfb_pkg
// Types and constants shared by the log frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

package lfb_pkg;

	localparam logic [7:0] SYNC_FIRST  = 8'hF5;
	localparam logic [7:0] SYNC_SECOND = 8'h5A;
	localparam logic [7:0] SYNC_SUM    = 8'(SYNC_FIRST + SYNC_SECOND);

	localparam logic REQ_START   = 1'b0;
	localparam logic REQ_PAYLOAD = 1'b1;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NO_FRAME   = 2'd1,
		ST_FRAME_BUSY = 2'd2
	} status_t;

	// position of a result within the words caused by one item
	typedef logic [2:0] res_idx_t;

	localparam res_idx_t IDX_SYNC0 = 3'd0;
	localparam res_idx_t IDX_SYNC1 = 3'd1;
	localparam res_idx_t IDX_TYPE  = 3'd2;
	localparam res_idx_t IDX_LENLO = 3'd3;
	localparam res_idx_t IDX_LENHI = 3'd4;
	localparam res_idx_t IDX_CSUM  = 3'd5;

	localparam res_idx_t N_ONE   = 3'd1;
	localparam res_idx_t N_TWO   = 3'd2;
	localparam res_idx_t N_HDR   = 3'd5;
	localparam res_idx_t N_HDR_Z = 3'd6;

endpackage

`default_nettype wire

>>> hdl/log_frame_builder.sv
// ----------------------------------------------------------------------------
// log_frame_builder: an accepted item waits in the input stage, which takes a new
// item when empty or as the held item's last word loads into the output register.
// Output gives one word per cycle while out_stall is low; a payload item gives
// one word (two on close), a start item five (six for a zero-length frame), a misused item one.
// Reset closes any frame and clears the checksum and the pending words.
// ----------------------------------------------------------------------------
`default_nettype none

module log_frame_builder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        req_type,
	input  wire logic [7:0]  frame_type,
	input  wire logic [15:0] payload_length,
	input  wire logic [7:0]  payload_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             run_last,
	output logic             frame_end,
	output logic [1:0]       status
);

	// input stage
	logic                s1_vld_q;
	logic                req_s1;
	logic [7:0]          ftype_s1;
	logic [15:0]         len_s1;
	logic [7:0]          pbyte_s1;
	lfb_pkg::res_idx_t   idx_q;

	// frame state
	logic                frame_open_q;
	logic [15:0]         remain_q;
	logic [7:0]          sum_q;

	// output register
	logic                out_vld_q;
	logic [7:0]          out_byte_q;
	logic                out_last_q;
	logic                out_end_q;
	lfb_pkg::status_t    out_st_q;

	lfb_pkg::res_idx_t   n_res;
	logic [7:0]          hdr_sum;
	logic [7:0]          pay_sum;
	logic [7:0]          res_byte;
	logic                res_end;
	lfb_pkg::status_t    res_st;
	logic                res_last;
	logic                load;
	logic                in_take;

	assign hdr_sum = 8'(lfb_pkg::SYNC_SUM + ftype_s1 + len_s1[7:0] + len_s1[15:8]);
	assign pay_sum = 8'(sum_q + pbyte_s1);

	// select the word at idx_q for the held item
	always_comb begin
		n_res    = lfb_pkg::N_ONE;
		res_byte = 8'h00;
		res_end  = 1'b0;
		res_st   = lfb_pkg::ST_OK;
		if (req_s1 == lfb_pkg::REQ_START) begin
			if (frame_open_q) begin
				res_st = lfb_pkg::ST_FRAME_BUSY;
			end else begin
				n_res = (len_s1 == 16'd0) ? lfb_pkg::N_HDR_Z : lfb_pkg::N_HDR;
				case (idx_q)
					lfb_pkg::IDX_SYNC0: res_byte = lfb_pkg::SYNC_FIRST;
					lfb_pkg::IDX_SYNC1: res_byte = lfb_pkg::SYNC_SECOND;
					lfb_pkg::IDX_TYPE:  res_byte = ftype_s1;
					lfb_pkg::IDX_LENLO: res_byte = len_s1[7:0];
					lfb_pkg::IDX_LENHI: res_byte = len_s1[15:8];
					lfb_pkg::IDX_CSUM: begin
						res_byte = hdr_sum;
						res_end  = 1'b1;
					end
					default: res_byte = 8'h00;
				endcase
			end
		end else begin
			if (!frame_open_q) begin
				res_st = lfb_pkg::ST_NO_FRAME;
			end else begin
				n_res = (remain_q == 16'd1) ? lfb_pkg::N_TWO : lfb_pkg::N_ONE;
				if (idx_q == lfb_pkg::res_idx_t'(0)) begin
					res_byte = pbyte_s1;
				end else begin
					res_byte = pay_sum;
					res_end  = 1'b1;
				end
			end
		end
	end

	assign res_last = (idx_q == 3'(n_res - 3'd1));
	assign load     = s1_vld_q && (!out_vld_q || !out_stall);
	assign in_stall = s1_vld_q && !(load && res_last);
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (in_take) begin
				s1_vld_q <= 1'b1;
			end else if (load && res_last) begin
				s1_vld_q <= 1'b0;
			end
			if (load) begin
				idx_q <= res_last ? '0 : 3'(idx_q + 3'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			req_s1   <= req_type;
			ftype_s1 <= frame_type;
			len_s1   <= payload_length;
			pbyte_s1 <= payload_byte;
		end
	end

	// commit the item's effect on the frame with its last word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
			remain_q     <= '0;
			sum_q        <= '0;
		end else if (load && res_last && res_st == lfb_pkg::ST_OK) begin
			if (req_s1 == lfb_pkg::REQ_START) begin
				frame_open_q <= (len_s1 != 16'd0);
				remain_q     <= len_s1;
				sum_q        <= (len_s1 != 16'd0) ? hdr_sum : 8'h00;
			end else if (remain_q == 16'd1) begin
				frame_open_q <= 1'b0;
				remain_q     <= '0;
				sum_q        <= '0;
			end else begin
				remain_q <= 16'(remain_q - 16'd1);
				sum_q    <= pay_sum;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= res_byte;
			out_last_q <= res_last;
			out_end_q  <= res_end;
			out_st_q   <= res_st;
		end
	end

	assign out_valid = out_vld_q;
	assign out_byte  = out_byte_q;
	assign run_last  = out_last_q;
	assign frame_end = out_end_q;
	assign status    = 2'(out_st_q);

`include "log_frame_builder_macros.svh"

	`LFB_ASSERT_IMPL(a_open_has_count, frame_open_q, remain_q != 16'd0, "open frame with no bytes left")
	`LFB_ASSERT_IMPL(a_end_is_last, out_vld_q && out_end_q, out_last_q, "checksum word not last of its item")
	`LFB_ASSERT_IMPL(a_err_clean, out_vld_q && out_st_q != lfb_pkg::ST_OK, out_byte_q == 8'h00 && out_last_q && !out_end_q, "error word malformed")
	`LFB_ASSERT_IMPL(a_idle_no_stall, !s1_vld_q, !in_stall, "stall with empty input stage")
	`LFB_ASSERT_NEXT(a_close_on_csum, load && res_end, !frame_open_q && sum_q == 8'h00, "frame still open after checksum")

endmodule

`default_nettype wire
